>>> src/dcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dcm_pkg;

  typedef struct packed {
    logic               cmd;
    logic               negative;
    logic [3:0]         opcode;
    logic [9:0]         operand_a;
    logic [9:0]         operand_b;
    logic [9:0]         operand_c;
    logic signed [31:0] word_value;
  } dcm_in_t;

  typedef struct packed {
    logic [9:0]         next_ip;
    logic               halted;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               card_taken;
    logic [1:0]         fault;
  } dcm_out_t;

  localparam logic [9:0] IpSpan = 10'd1000;

  localparam logic [1:0] FaultNone  = 2'd0;
  localparam logic [1:0] FaultDivZ  = 2'd1;
  localparam logic [1:0] FaultRange = 2'd2;

  localparam logic [3:0] OpMove  = 4'd0;
  localparam logic [3:0] OpAdd   = 4'd1;
  localparam logic [3:0] OpMul   = 4'd2;
  localparam logic [3:0] OpSq    = 4'd3;
  localparam logic [3:0] OpBeq   = 4'd4;
  localparam logic [3:0] OpBge   = 4'd5;
  localparam logic [3:0] OpIdx   = 4'd6;
  localparam logic [3:0] OpIncB  = 4'd7;
  localparam logic [3:0] OpCard  = 4'd8;
  localparam logic [3:0] OpHalt  = 4'd9;

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLR,
    DP_RD_A,
    DP_RD_B,
    DP_RD_C,
    DP_RD_IDX,
    DP_MUL,
    DP_DIV_START,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_WRITE,
    DP_SQR
  } dp_op_e;

  typedef enum logic [2:0] {
    SRC_ALU_ADD,
    SRC_ALU_SUB,
    SRC_MUL,
    SRC_DIV,
    SRC_A,
    SRC_INC,
    SRC_CARD,
    SRC_IDX
  } wsrc_e;

  typedef enum logic [1:0] {
    WA_C,
    WA_A,
    WA_IDX
  } waddr_e;

  typedef struct packed {
    dp_op_e op;
    wsrc_e  wsrc;
    waddr_e waddr;
    logic   idx_from_b;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic b_zero;
    logic idx_ok;
    logic eq;
    logic lt;
    logic inc_lt;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> src/dcm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module dcm_datapath
  import dcm_pkg::*;
#(
  parameter int DATA_DEPTH = 1000,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire dp_cmd_t cmd_i,
  input  wire dcm_in_t item_i,
  output dp_stat_t stat_o,
  output logic [WORD_WIDTH-1:0] print_o
);

  localparam int AW = $clog2(DATA_DEPTH);
  localparam int CW = $clog2(WORD_WIDTH + 1);
  localparam int XW = WORD_WIDTH + 12;

  logic [WORD_WIDTH-1:0] mem [DATA_DEPTH];
  logic [WORD_WIDTH-1:0] rdata_q;
  logic [WORD_WIDTH-1:0] rdata_q_hold;
  logic [WORD_WIDTH-1:0] a_q, b_q, c_q, res_q;
  logic [AW-1:0]         clr_q;
  logic [AW-1:0]         raddr, waddr;
  logic                  rvalid, wen;
  logic [WORD_WIDTH-1:0] wdata;
  logic [9:0]            idx_addr_q;
  logic                  idx_ok_q;
  logic                  idx_ok_c;
  logic [WORD_WIDTH-1:0] rem_q, quo_q, dvs_q;
  logic                  qneg_q;
  logic [CW-1:0]         cnt_q;
  logic [WORD_WIDTH:0]   trial;
  logic [WORD_WIDTH-1:0] card;
  logic signed [XW-1:0]  ea;
  logic [9:0]            ibase;
  logic [WORD_WIDTH-1:0] iw;
  logic                  a_in;
  logic [WORD_WIDTH-1:0] inc_a, inc_b;

  assign card = WORD_WIDTH'(item_i.word_value);

  function automatic logic in_range(input logic [9:0] ad);
    return {22'd0, ad} < 32'(DATA_DEPTH);
  endfunction

  always_comb begin
    raddr  = '0;
    rvalid = 1'b0;
    unique case (cmd_i.op)
      DP_RD_A:   begin raddr = AW'(item_i.operand_a); rvalid = in_range(item_i.operand_a); end
      DP_RD_B:   begin raddr = AW'(item_i.operand_b); rvalid = in_range(item_i.operand_b); end
      DP_RD_C:   begin raddr = AW'(item_i.operand_c); rvalid = in_range(item_i.operand_c); end
      DP_RD_IDX: begin raddr = AW'(idx_addr_q); rvalid = idx_ok_q; end
      default:   ;
    endcase
  end

  always_comb begin
    wen   = 1'b0;
    waddr = AW'(item_i.operand_c);
    wdata = '0;
    if (cmd_i.op == DP_CLR) begin
      wen   = 1'b1;
      waddr = clr_q;
    end else if (cmd_i.op == DP_WRITE) begin
      unique case (cmd_i.waddr)
        WA_C:    begin waddr = AW'(item_i.operand_c); wen = in_range(item_i.operand_c); end
        WA_A:    begin waddr = AW'(item_i.operand_a); wen = in_range(item_i.operand_a); end
        WA_IDX:  begin waddr = AW'(idx_addr_q); wen = idx_ok_q; end
        default: ;
      endcase
      unique case (cmd_i.wsrc)
        SRC_ALU_ADD: wdata = a_q + b_q;
        SRC_ALU_SUB: wdata = a_q - b_q;
        SRC_MUL:     wdata = res_q;
        SRC_DIV:     wdata = res_q;
        SRC_A:       wdata = a_q;
        SRC_INC:     wdata = a_q + WORD_WIDTH'(1);
        SRC_CARD:    wdata = card;
        SRC_IDX:     wdata = rdata_q_hold;
        default:     wdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // rvalid sampled alongside read data
  logic rvalid_q;
  dp_op_e lastop_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      lastop_q <= DP_NOP;
      clr_q    <= '0;
    end else begin
      rvalid_q <= rvalid;
      lastop_q <= cmd_i.op;
      if (cmd_i.op == DP_CLR) clr_q <= clr_q + AW'(1);
    end
  end

  logic [WORD_WIDTH-1:0] rd;
  assign rd = rvalid_q ? rdata_q : '0;

  assign ibase    = cmd_i.idx_from_b ? item_i.operand_b : item_i.operand_a;
  assign iw       = cmd_i.idx_from_b ? c_q : b_q;
  assign ea       = XW'(signed'({1'b0, ibase})) + XW'(signed'(iw));
  assign idx_ok_c = (ea >= 0) && (ea < XW'(DATA_DEPTH));
  assign trial    = {rem_q[WORD_WIDTH-2:0], quo_q[WORD_WIDTH-1]} - {1'b0, dvs_q};

  assign a_in  = in_range(item_i.operand_a);
  assign inc_a = a_in ? a_q + WORD_WIDTH'(1) : '0;
  assign inc_b = (a_in && item_i.operand_a == item_i.operand_b) ? inc_a : b_q;

  always_ff @(posedge clk_i) begin
    unique case (lastop_q)
      DP_RD_A: a_q <= rd;
      DP_RD_B: b_q <= rd;
      DP_RD_C: c_q <= rd;
      DP_RD_IDX: ;
      default: ;
    endcase
    if (lastop_q == DP_RD_IDX) rdata_q_hold <= rdata_q;
    if (cmd_i.op == DP_MUL || cmd_i.op == DP_SQR)
      res_q <= a_q * ((cmd_i.op == DP_SQR) ? a_q : b_q);
    idx_ok_q   <= idx_ok_c;
    idx_addr_q <= 10'(ea);
    if (cmd_i.op == DP_DIV_START) begin
      qneg_q <= a_q[WORD_WIDTH-1] ^ b_q[WORD_WIDTH-1];
      quo_q  <= a_q[WORD_WIDTH-1] ? -a_q : a_q;
      dvs_q  <= b_q[WORD_WIDTH-1] ? -b_q : b_q;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.op == DP_DIV_STEP) begin
      if (!trial[WORD_WIDTH]) rem_q <= trial[WORD_WIDTH-1:0];
      else rem_q <= {rem_q[WORD_WIDTH-2:0], quo_q[WORD_WIDTH-1]};
      quo_q <= {quo_q[WORD_WIDTH-2:0], ~trial[WORD_WIDTH]};
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.op == DP_DIV_END) begin
      res_q <= qneg_q ? -quo_q : quo_q;
    end
  end

  logic [WORD_WIDTH-1:0] a_cur;
  assign a_cur = a_q;

  assign stat_o.clr_done = (32'(clr_q) == 32'(DATA_DEPTH - 1));
  assign stat_o.div_done = (32'(cnt_q) == 32'(WORD_WIDTH - 1));
  assign stat_o.b_zero   = (b_q == '0);
  assign stat_o.idx_ok   = idx_ok_c;
  assign stat_o.eq       = (a_cur == b_q);
  assign stat_o.lt       = $signed(a_cur) < $signed(b_q);
  assign stat_o.inc_lt   = $signed(inc_a) < $signed(inc_b);
  assign print_o         = a_q;

endmodule
`default_nettype wire

>>> src/dcm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module dcm_ctrl
  import dcm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire dcm_in_t in_word_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output dcm_out_t out_word_o,
  input  wire dp_stat_t stat_i,
  input  wire logic [31:0] print_i,
  output dp_cmd_t cmd_o,
  output dcm_in_t item_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_LATCH, S_EXEC,
    S_IDX_RD, S_IDX_WAIT, S_MUL, S_DIV, S_DIV_END, S_WR, S_INC_RD, S_DONE
  } state_e;

  state_e   state_q;
  dcm_in_t  item_q;
  dcm_out_t res_q;
  logic     out_v_q;
  logic [9:0] ip_q;
  logic       halt_q;
  wsrc_e      wsrc_q;
  waddr_e     wa_q;
  logic       ixb_q;

  logic [9:0] tgt, ip_inc;
  assign tgt    = (item_q.operand_c >= IpSpan) ? item_q.operand_c - IpSpan : item_q.operand_c;
  assign ip_inc = (ip_q == IpSpan - 10'd1) ? 10'd0 : ip_q + 10'd1;

  assign in_stall_o  = (state_q != S_IDLE) || out_v_q;
  assign out_valid_o = out_v_q;
  assign out_word_o  = res_q;
  assign item_o      = item_q;

  always_comb begin
    cmd_o.op         = DP_NOP;
    cmd_o.wsrc       = wsrc_q;
    cmd_o.waddr      = wa_q;
    cmd_o.idx_from_b = ixb_q;
    unique case (state_q)
      S_CLEAR:   cmd_o.op = DP_CLR;
      S_RD_A:    cmd_o.op = DP_RD_A;
      S_RD_B:    cmd_o.op = DP_RD_B;
      S_RD_C:    cmd_o.op = DP_RD_C;
      S_INC_RD:  cmd_o.op = DP_RD_B;
      S_IDX_RD:  cmd_o.op = DP_RD_IDX;
      S_MUL:     cmd_o.op = (item_q.opcode == OpSq) ? DP_SQR : DP_MUL;
      S_DIV:     cmd_o.op = DP_DIV_STEP;
      S_DIV_END: cmd_o.op = DP_DIV_END;
      S_WR:      cmd_o.op = DP_WRITE;
      S_EXEC:    cmd_o.op = (!item_q.negative && item_q.opcode == OpCard) ? DP_NOP :
                            (item_q.negative && item_q.opcode == OpMul) ? DP_DIV_START : DP_NOP;
      default:   cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      out_v_q <= 1'b0;
      ip_q    <= '0;
      halt_q  <= 1'b0;
      wsrc_q  <= SRC_A;
      wa_q    <= WA_C;
      ixb_q   <= 1'b0;
      item_q  <= '0;
      res_q   <= '0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: if (stat_i.clr_done) state_q <= S_IDLE;
        S_IDLE: if (in_valid_i && !out_v_q) begin
          item_q            <= in_word_i;
          res_q             <= '0;
          res_q.next_ip     <= ip_q;
          res_q.halted      <= halt_q;
          if (!in_word_i.cmd) begin
            wsrc_q <= SRC_CARD; wa_q <= WA_C;
            state_q <= S_WR;
          end else if (halt_q) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_RD_A;
          end
        end
        S_RD_A: state_q <= S_RD_B;
        S_RD_B: state_q <= S_RD_C;
        S_RD_C: state_q <= S_LATCH;
        S_LATCH: begin
          ixb_q   <= item_q.negative;
          ip_q    <= ip_inc;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_q.next_ip <= ip_q;
          state_q <= S_DONE;
          if (!item_q.negative) begin
            unique case (item_q.opcode)
              OpMove: begin wsrc_q <= SRC_A; wa_q <= WA_C; state_q <= S_WR; end
              OpAdd:  begin wsrc_q <= SRC_ALU_ADD; wa_q <= WA_C; state_q <= S_WR; end
              OpMul:  begin wsrc_q <= SRC_MUL; wa_q <= WA_C; state_q <= S_MUL; end
              OpSq:   begin wsrc_q <= SRC_MUL; wa_q <= WA_C; state_q <= S_MUL; end
              OpBeq:  if (stat_i.eq) begin ip_q <= tgt; res_q.next_ip <= tgt; end
              OpBge:  if (!stat_i.lt) begin ip_q <= tgt; res_q.next_ip <= tgt; end
              OpIdx:  begin
                wsrc_q <= SRC_IDX; wa_q <= WA_C;
                if (stat_i.idx_ok) state_q <= S_IDX_RD;
                else res_q.fault <= FaultRange;
              end
              OpIncB: begin
                wsrc_q <= SRC_INC; wa_q <= WA_A; state_q <= S_WR;
                if (stat_i.inc_lt) begin ip_q <= tgt; res_q.next_ip <= tgt; end
              end
              OpCard: begin
                wsrc_q <= SRC_CARD; wa_q <= WA_C; state_q <= S_WR;
                res_q.card_taken <= 1'b1;
              end
              OpHalt: begin halt_q <= 1'b1; res_q.halted <= 1'b1; end
              default: ;
            endcase
          end else begin
            unique case (item_q.opcode)
              OpAdd: begin wsrc_q <= SRC_ALU_SUB; wa_q <= WA_C; state_q <= S_WR; end
              OpMul: begin
                wsrc_q <= SRC_DIV; wa_q <= WA_C;
                if (stat_i.b_zero) res_q.fault <= FaultDivZ;
                else state_q <= S_DIV;
              end
              OpBeq: if (!stat_i.eq) begin ip_q <= tgt; res_q.next_ip <= tgt; end
              OpBge: if (stat_i.lt) begin ip_q <= tgt; res_q.next_ip <= tgt; end
              OpIdx: begin
                wsrc_q <= SRC_A; wa_q <= WA_IDX;
                if (stat_i.idx_ok) state_q <= S_WR;
                else res_q.fault <= FaultRange;
              end
              OpCard: begin
                res_q.print_valid <= 1'b1;
                res_q.print_value <= print_i;
              end
              default: ;
            endcase
          end
        end
        S_MUL: state_q <= S_WR;
        S_DIV: if (stat_i.div_done) state_q <= S_DIV_END;
        S_DIV_END: state_q <= S_WR;
        S_IDX_RD: state_q <= S_IDX_WAIT;
        S_IDX_WAIT: state_q <= S_WR;
        S_WR: begin
          if (item_q.cmd && !item_q.negative && item_q.opcode == OpIncB) begin
            wsrc_q <= SRC_A;
            state_q <= S_INC_RD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_INC_RD: state_q <= S_DONE;
        S_DONE: begin
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/decimal_card_machine_executor_core.sv
// Sequencing: an execute while halted goes straight to the done state, a load word writes
// its card first, and most instructions read operands A, B and C before they execute.
// Flow: one word at a time; no new word is taken until the result valid has been
// accepted by the consumer, and a divide runs through the serial restoring divider.
// Reset: asynchronous, active low; clears ip and halt,
// then sweeps data memory to zero with input stalled.
`timescale 1ns / 1ps
`default_nettype none
module decimal_card_machine_executor_core
  import dcm_pkg::*;
#(
  parameter int DATA_DEPTH = 1000,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dcm_in_t  in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output dcm_out_t      out_word_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  dcm_in_t  item;
  logic [WORD_WIDTH-1:0] pr;
  logic [31:0] pr32;

  assign pr32 = 32'(signed'(pr));

  dcm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .stat_i(stat), .print_i(pr32), .cmd_o(cmd), .item_o(item)
  );

  dcm_datapath #(.DATA_DEPTH(DATA_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(item), .stat_o(stat), .print_o(pr)
  );

  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.fault != 2'd3) else $error("bad fault");
  a_ip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.next_ip < 10'd1000) else $error("ip range");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while busy");

endmodule
`default_nettype wire
